@@ src/crpt_pkg.sv @@
// crpt_pkg: shared constants, types and the arctangent table for the
// contact region point test. No dependencies.
package crpt_pkg;

  localparam int CRPT_COORD_WIDTH  = 16;
  localparam int CRPT_CORDIC_STEPS = 16;
  localparam int CRPT_GUARD_BITS   = 3;   // headroom for quarter turn and CORDIC gain
  localparam int CRPT_ACC_W        = 18;  // angle accumulator before saturation
  localparam int CRPT_ANG_W        = 16;  // binary angle, pi = 32768
  localparam int CRPT_IDX_W        = 3;
  localparam int CRPT_NUM_LANES    = 3;

  typedef enum logic [CRPT_IDX_W-1:0] {
    REG_X_LIM     = 3'd0,
    REG_Y_LIM     = 3'd1,
    REG_Z_LIM     = 3'd2,
    REG_ANG_X_LIM = 3'd3,
    REG_ANG_Y_LIM = 3'd4,
    REG_ANG_Z_LIM = 3'd5
  } crpt_reg_t;

  // Control word that travels alongside the vectors down the chain.
  typedef struct packed {
    logic       valid;
    logic       lin_ok;
    logic [2:0] zero;
  } crpt_ctl_t;

  // atan(2^-i) in binary-angle units, rounded to nearest
  function automatic logic signed [CRPT_ACC_W-1:0] crpt_atan(input int idx);
    logic signed [CRPT_ACC_W-1:0] v;
    case (idx)
      0:       v = 18'sd8192;
      1:       v = 18'sd4836;
      2:       v = 18'sd2555;
      3:       v = 18'sd1297;
      4:       v = 18'sd651;
      5:       v = 18'sd326;
      6:       v = 18'sd163;
      7:       v = 18'sd81;
      8:       v = 18'sd41;
      9:       v = 18'sd20;
      10:      v = 18'sd10;
      11:      v = 18'sd5;
      12:      v = 18'sd3;
      13:      v = 18'sd1;
      14:      v = 18'sd1;
      default: v = 18'sd0;
    endcase
    return v;
  endfunction

endpackage

@@ src/contact_region_point_test_top.sv @@
// contact_region_point_test_top: point-in-contact-region test with linear and
// angular limits; CORDIC chain of crpt_cell. Uses crpt_pkg, crpt_limit, crpt_cell.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_point_x, in_point_y, in_point_z
//   out      output     out_valid/out_stall  out_inside_res
//   cfg      input      cfg_wr_en            cfg_index, cfg_wdata
//
// One point enters per cycle while the chain is not held; each result passes
// through the input stage, one cell per CORDIC step and the output register.
// Reset clears the limit registers (all limits off) and the valid bits. The
// whole chain holds while the output register is full and stalled; in_stall
// is high exactly then.
module contact_region_point_test_top import crpt_pkg::*; #(
  parameter int COORD_WIDTH  = CRPT_COORD_WIDTH,
  parameter int CORDIC_STEPS = CRPT_CORDIC_STEPS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [COORD_WIDTH-1:0] in_point_x,
  input  logic [COORD_WIDTH-1:0] in_point_y,
  input  logic [COORD_WIDTH-1:0] in_point_z,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_inside_res,
  input  logic                   cfg_wr_en,
  input  logic [CRPT_IDX_W-1:0]  cfg_index,
  input  logic [((2*COORD_WIDTH > 32) ? 2*COORD_WIDTH : 32)-1:0] cfg_wdata
);

  localparam int IW  = COORD_WIDTH + CRPT_GUARD_BITS;
  localparam int LW  = 2 * COORD_WIDTH;
  localparam int AW2 = 2 * CRPT_ANG_W;
  localparam logic signed [CRPT_ACC_W-1:0] QUARTER = 18'sd16384;
  localparam logic signed [CRPT_ACC_W-1:0] ANG_MAX = 18'sd32767;
  localparam logic signed [CRPT_ACC_W-1:0] ANG_MIN = -18'sd32768;

  // limit registers
  logic [LW-1:0]  lin_lim_r [CRPT_NUM_LANES];
  logic [AW2-1:0] ang_lim_r [CRPT_NUM_LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CRPT_NUM_LANES; i++) begin
        lin_lim_r[i] <= '0;
        ang_lim_r[i] <= '0;
      end
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_X_LIM:     lin_lim_r[0] <= cfg_wdata[LW-1:0];
        REG_Y_LIM:     lin_lim_r[1] <= cfg_wdata[LW-1:0];
        REG_Z_LIM:     lin_lim_r[2] <= cfg_wdata[LW-1:0];
        REG_ANG_X_LIM: ang_lim_r[0] <= cfg_wdata[AW2-1:0];
        REG_ANG_Y_LIM: ang_lim_r[1] <= cfg_wdata[AW2-1:0];
        REG_ANG_Z_LIM: ang_lim_r[2] <= cfg_wdata[AW2-1:0];
        default: ;
      endcase
    end
  end

  logic out_valid_r;
  logic out_inside_res_r;
  logic adv;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // linear limits, checked on the raw point
  logic [COORD_WIDTH-1:0]    pt [CRPT_NUM_LANES];
  logic [CRPT_NUM_LANES-1:0] lin_ok;

  assign pt[0] = in_point_x;
  assign pt[1] = in_point_y;
  assign pt[2] = in_point_z;

  for (genvar a = 0; a < CRPT_NUM_LANES; a++) begin : g_lin
    crpt_limit #(.W(COORD_WIDTH)) u_lim (
      .lim (lin_lim_r[a]),
      .val (pt[a]),
      .ok  (lin_ok[a])
    );
  end

  // lane 0: atan2(z,y), lane 1: atan2(x,z), lane 2: atan2(y,x)
  logic signed [IW-1:0] num_ext [CRPT_NUM_LANES];
  logic signed [IW-1:0] den_ext [CRPT_NUM_LANES];

  assign num_ext[0] = $signed({{CRPT_GUARD_BITS{in_point_z[COORD_WIDTH-1]}}, in_point_z});
  assign den_ext[0] = $signed({{CRPT_GUARD_BITS{in_point_y[COORD_WIDTH-1]}}, in_point_y});
  assign num_ext[1] = $signed({{CRPT_GUARD_BITS{in_point_x[COORD_WIDTH-1]}}, in_point_x});
  assign den_ext[1] = $signed({{CRPT_GUARD_BITS{in_point_z[COORD_WIDTH-1]}}, in_point_z});
  assign num_ext[2] = $signed({{CRPT_GUARD_BITS{in_point_y[COORD_WIDTH-1]}}, in_point_y});
  assign den_ext[2] = $signed({{CRPT_GUARD_BITS{in_point_x[COORD_WIDTH-1]}}, in_point_x});

  logic [CRPT_NUM_LANES-1:0][IW-1:0]         pre_n_nxt, pre_d_nxt;
  logic [CRPT_NUM_LANES-1:0][CRPT_ACC_W-1:0] pre_acc_nxt;
  logic [CRPT_NUM_LANES-1:0]                 pre_zero_nxt;

  // quarter turn into the right half plane
  for (genvar g = 0; g < CRPT_NUM_LANES; g++) begin : g_pre
    always_comb begin
      pre_zero_nxt[g] = (num_ext[g] == '0) && (den_ext[g] == '0);
      if (den_ext[g][IW-1]) begin
        if (!num_ext[g][IW-1]) begin
          pre_d_nxt[g]   = num_ext[g];
          pre_n_nxt[g]   = -den_ext[g];
          pre_acc_nxt[g] = QUARTER;
        end else begin
          pre_d_nxt[g]   = -num_ext[g];
          pre_n_nxt[g]   = den_ext[g];
          pre_acc_nxt[g] = -QUARTER;
        end
      end else begin
        pre_d_nxt[g]   = den_ext[g];
        pre_n_nxt[g]   = num_ext[g];
        pre_acc_nxt[g] = '0;
      end
    end
  end

  crpt_ctl_t                               pre_ctl_r;
  logic [CRPT_NUM_LANES-1:0][IW-1:0]         pre_n_r, pre_d_r;
  logic [CRPT_NUM_LANES-1:0][CRPT_ACC_W-1:0] pre_acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_ctl_r.valid <= 1'b0;
    end else if (adv) begin
      pre_ctl_r.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pre_ctl_r.lin_ok <= &lin_ok;
      pre_ctl_r.zero   <= pre_zero_nxt;
      pre_n_r          <= pre_n_nxt;
      pre_d_r          <= pre_d_nxt;
      pre_acc_r        <= pre_acc_nxt;
    end
  end

  // CORDIC chain
  crpt_ctl_t                               chn_ctl [CORDIC_STEPS+1];
  logic [CRPT_NUM_LANES-1:0][IW-1:0]         chn_n   [CORDIC_STEPS+1];
  logic [CRPT_NUM_LANES-1:0][IW-1:0]         chn_d   [CORDIC_STEPS+1];
  logic [CRPT_NUM_LANES-1:0][CRPT_ACC_W-1:0] chn_acc [CORDIC_STEPS+1];

  assign chn_ctl[0] = pre_ctl_r;
  assign chn_n[0]   = pre_n_r;
  assign chn_d[0]   = pre_d_r;
  assign chn_acc[0] = pre_acc_r;

  for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_chain
    crpt_cell #(.IW(IW), .STEP_IDX(s)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .ctl_i (chn_ctl[s]),
      .n_i   (chn_n[s]),
      .d_i   (chn_d[s]),
      .acc_i (chn_acc[s]),
      .ctl_o (chn_ctl[s+1]),
      .n_o   (chn_n[s+1]),
      .d_o   (chn_d[s+1]),
      .acc_o (chn_acc[s+1])
    );
  end

  // saturate, force the origin to zero, check the angular limits
  crpt_ctl_t                 last_ctl;
  logic [CRPT_NUM_LANES-1:0] ang_ok;

  assign last_ctl = chn_ctl[CORDIC_STEPS];

  for (genvar g = 0; g < CRPT_NUM_LANES; g++) begin : g_ang
    logic signed [CRPT_ACC_W-1:0] acc_s;
    logic [CRPT_ANG_W-1:0]        ang;

    assign acc_s = $signed(chn_acc[CORDIC_STEPS][g]);

    always_comb begin
      if (last_ctl.zero[g]) begin
        ang = '0;
      end else if (acc_s > ANG_MAX) begin
        ang = ANG_MAX[CRPT_ANG_W-1:0];
      end else if (acc_s < ANG_MIN) begin
        ang = ANG_MIN[CRPT_ANG_W-1:0];
      end else begin
        ang = acc_s[CRPT_ANG_W-1:0];
      end
    end

    crpt_limit #(.W(CRPT_ANG_W)) u_lim (
      .lim (ang_lim_r[g]),
      .val (ang),
      .ok  (ang_ok[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= last_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_inside_res_r <= last_ctl.lin_ok & (&ang_ok);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_res_r;

endmodule

@@ src/crpt_limit.sv @@
// crpt_limit: signed interval test on one value against packed low/high bounds.
// Equal bounds switch the limit off. No dependencies.
module crpt_limit #(
  parameter int W = 16
) (
  input  logic [2*W-1:0] lim,
  input  logic [W-1:0]   val,
  output logic           ok
);

  logic signed [W-1:0] lo;
  logic signed [W-1:0] hi;
  logic signed [W-1:0] v;

  assign lo = $signed(lim[W-1:0]);
  assign hi = $signed(lim[2*W-1:W]);
  assign v  = $signed(val);

  assign ok = (lim[W-1:0] == lim[2*W-1:W]) || (!(v < lo) && !(hi < v));

endmodule

@@ src/crpt_cell.sv @@
// crpt_cell: one CORDIC vectoring micro-rotation for all three angle lanes,
// registered, handing its vectors to the next cell. Uses crpt_pkg.
module crpt_cell import crpt_pkg::*; #(
  parameter int IW       = 19,
  parameter int STEP_IDX = 0
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    adv,
  input  crpt_ctl_t                               ctl_i,
  input  logic [CRPT_NUM_LANES-1:0][IW-1:0]         n_i,
  input  logic [CRPT_NUM_LANES-1:0][IW-1:0]         d_i,
  input  logic [CRPT_NUM_LANES-1:0][CRPT_ACC_W-1:0] acc_i,
  output crpt_ctl_t                               ctl_o,
  output logic [CRPT_NUM_LANES-1:0][IW-1:0]         n_o,
  output logic [CRPT_NUM_LANES-1:0][IW-1:0]         d_o,
  output logic [CRPT_NUM_LANES-1:0][CRPT_ACC_W-1:0] acc_o
);

  localparam logic signed [CRPT_ACC_W-1:0] ATAN = crpt_atan(STEP_IDX);

  crpt_ctl_t                               ctl_r;
  logic [CRPT_NUM_LANES-1:0][IW-1:0]         n_r, n_nxt;
  logic [CRPT_NUM_LANES-1:0][IW-1:0]         d_r, d_nxt;
  logic [CRPT_NUM_LANES-1:0][CRPT_ACC_W-1:0] acc_r, acc_nxt;

  for (genvar g = 0; g < CRPT_NUM_LANES; g++) begin : g_lane
    logic signed [IW-1:0]         n_s, d_s, dn, dd;
    logic signed [CRPT_ACC_W-1:0] a_s;

    assign n_s = $signed(n_i[g]);
    assign d_s = $signed(d_i[g]);
    assign a_s = $signed(acc_i[g]);
    assign dn  = n_s >>> STEP_IDX;
    assign dd  = d_s >>> STEP_IDX;

    // turn clockwise while n is non-negative, counter-clockwise otherwise
    always_comb begin
      if (!n_s[IW-1]) begin
        d_nxt[g]   = d_s + dn;
        n_nxt[g]   = n_s - dd;
        acc_nxt[g] = a_s + ATAN;
      end else begin
        d_nxt[g]   = d_s - dn;
        n_nxt[g]   = n_s + dd;
        acc_nxt[g] = a_s - ATAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (adv) begin
      ctl_r.valid <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_r.lin_ok <= ctl_i.lin_ok;
      ctl_r.zero   <= ctl_i.zero;
      n_r          <= n_nxt;
      d_r          <= d_nxt;
      acc_r        <= acc_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign n_o   = n_r;
  assign d_o   = d_r;
  assign acc_o = acc_r;

endmodule

@@ src/crpt_checker.sv @@
// crpt_checker: port-level assertions for contact_region_point_test_top,
// attached by the bind below. Depends on the top level's port names only.
module crpt_checker (
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_inside_res
);

  // a stalled result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_inside_res))
    else $error("result changed while stalled");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // input backs up only behind a full, stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // never stall the input in a cycle where the output drains
  a_no_spurious_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output drains");

endmodule

bind contact_region_point_test_top crpt_checker u_crpt_checker (.*);

@@ test/contact_region_point_test_top_tb.sv @@
// Self-checking testbench for contact_region_point_test_top: points are pushed through the
// valid/stall input channel and each inside/outside answer is checked against a local
// fixed-point CORDIC predictor. Depends on crpt_pkg and the top module only.
module contact_region_point_test_top_tb;
  import crpt_pkg::*;

  localparam int CFG_W = (2*CRPT_COORD_WIDTH > 32) ? 2*CRPT_COORD_WIDTH : 32;
  localparam logic [CRPT_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CRPT_IDX_W-1:0] REG_UNUSED_HI = 3'd7;
  localparam logic [31:0] LIM_FULL     = {16'h7fff, 16'h8000};
  localparam logic [31:0] LIM_REVERSED = {16'h8000, 16'h7fff};

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
  } point_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [15:0]           in_point_x = '0;
  logic [15:0]           in_point_y = '0;
  logic [15:0]           in_point_z = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_inside_res;
  logic                  cfg_wr_en = 1'b0;
  logic [CRPT_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]      cfg_wdata = '0;

  logic [31:0] lim_regs [6];
  point_t      point_q [$];
  bit          inside_q [$];
  logic        in_taken = 1'b0;
  int          in_idle_pct = 27;
  int          out_idle_pct = 77;
  int          bad_results = 0;

  contact_region_point_test_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .in_point_z    (in_point_z),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_inside_res(out_inside_res),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always #10 clk = ~clk;

  // atan(2^-i) in binary-angle units
  function automatic longint atan_step(int i);
    case (i)
      0:  return 8192;
      1:  return 4836;
      2:  return 2555;
      3:  return 1297;
      4:  return 651;
      5:  return 326;
      6:  return 163;
      7:  return 81;
      8:  return 41;
      9:  return 20;
      10: return 10;
      11: return 5;
      12: return 3;
      13: return 1;
      14: return 1;
      default: return 0;
    endcase
  endfunction

  function automatic longint bam_atan2(longint n_in, longint d_in);
    longint n, d, t, dn, dd, acc;
    int i;
    n = n_in;
    d = d_in;
    acc = 0;
    if (n == 0 && d == 0) return 0;
    // fold the left half plane over with a quarter turn
    if (d < 0) begin
      t = d;
      if (n >= 0) begin
        d = n;
        n = -t;
        acc = 16384;
      end else begin
        d = -n;
        n = t;
        acc = -16384;
      end
    end
    for (i = 0; i < CRPT_CORDIC_STEPS && i < 24; i++) begin
      dn = n >>> i;
      dd = d >>> i;
      if (n >= 0) begin
        d = d + dn;
        n = n - dd;
        acc = acc + atan_step(i);
      end else begin
        d = d - dn;
        n = n + dd;
        acc = acc - atan_step(i);
      end
    end
    if (acc > 32767) acc = 32767;
    if (acc < -32768) acc = -32768;
    return acc;
  endfunction

  function automatic bit span_ok(logic [31:0] lim, longint v);
    logic signed [15:0] lo, hi;
    lo = lim[15:0];
    hi = lim[31:16];
    if (lim[15:0] == lim[31:16]) return 1'b1;
    return !(v < lo || hi < v);
  endfunction

  function automatic bit point_inside(logic [15:0] px, logic [15:0] py, logic [15:0] pz);
    longint x, y, z;
    x = $signed(px);
    y = $signed(py);
    z = $signed(pz);
    return span_ok(lim_regs[REG_X_LIM], x) && span_ok(lim_regs[REG_Y_LIM], y) &&
           span_ok(lim_regs[REG_Z_LIM], z) &&
           span_ok(lim_regs[REG_ANG_X_LIM], bam_atan2(z, y)) &&
           span_ok(lim_regs[REG_ANG_Y_LIM], bam_atan2(x, z)) &&
           span_ok(lim_regs[REG_ANG_Z_LIM], bam_atan2(y, x));
  endfunction

  function automatic logic [31:0] pick_limit();
    logic [15:0] a, b, t;
    a = 16'($urandom);
    b = 16'($urandom);
    case ($urandom_range(7))
      0, 1, 2: return {a, a};
      3:       return LIM_FULL;
      default: begin
        if ($signed(a) > $signed(b)) begin
          t = a;
          a = b;
          b = t;
        end
        return {b, a};
      end
    endcase
  endfunction

  // bias half the picks into an enabled span so full hits stay common
  function automatic logic [15:0] pick_coord(logic [31:0] lim);
    int lo, hi;
    lo = $signed(lim[15:0]);
    hi = $signed(lim[31:16]);
    if (lo < hi && $urandom_range(1) == 1)
      return 16'(lo + int'($urandom_range(0, hi - lo)));
    case ($urandom_range(11))
      0:       return 16'h0000;
      1:       return 16'h8000;
      2:       return 16'h7fff;
      3, 4:    return 16'(int'($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic write_limit(input logic [CRPT_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx <= REG_ANG_Z_LIM) lim_regs[idx] = val[31:0];
  endtask

  task automatic push_point(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
    point_q.push_back({x, y, z});
  endtask

  // wait until every point is sent and every answer is back
  task automatic drain();
    while (point_q.size() != 0 || in_valid || inside_q.size() != 0) @(posedge clk);
  endtask

  // input driver
  always @(negedge clk) begin : point_driver
    point_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (point_q.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        nxt = point_q.pop_front();
        in_valid   <= 1'b1;
        in_point_x <= nxt.x;
        in_point_y <= nxt.y;
        in_point_z <= nxt.z;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < out_idle_pct);
  end

  // monitor: predict on each input transfer, check on each output transfer
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall)
        inside_q.push_back(point_inside(in_point_x, in_point_y, in_point_z));
      if (out_valid && !out_stall) begin
        if (inside_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual inside_res=%0b",
                   $time, out_inside_res);
          bad_results++;
        end else if (out_inside_res !== inside_q[0]) begin
          $display("%0t: inside_res mismatch, expected %0b, actual %0b",
                   $time, inside_q[0], out_inside_res);
          bad_results++;
          void'(inside_q.pop_front());
        end else begin
          void'(inside_q.pop_front());
        end
      end
    end
  end

  initial begin
    int r, n;
    for (r = 0; r < 6; r++) lim_regs[r] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // all limits off after reset
    push_point(16'h0000, 16'h0000, 16'h0000);
    push_point(16'h7fff, 16'h7fff, 16'h7fff);
    push_point(16'h8000, 16'h8000, 16'h8000);
    push_point(16'h8000, 16'h0000, 16'h0000);
    drain();

    // near-pi window about x, narrow z, disabled limits with nonzero patterns
    write_limit(REG_X_LIM, LIM_FULL);
    write_limit(REG_Y_LIM, {16'h1234, 16'h1234});
    write_limit(REG_Z_LIM, {16'h1000, 16'hf000});
    write_limit(REG_ANG_X_LIM, {16'h7fff, 16'd30000});
    write_limit(REG_ANG_Y_LIM, 32'h0000_0000);
    write_limit(REG_ANG_Z_LIM, LIM_FULL);
    write_limit(REG_UNUSED_LO, $urandom);
    write_limit(REG_UNUSED_HI, 32'hffff_ffff);
    push_point(16'h0000, 16'hf000, 16'h0000);
    push_point(16'h0000, 16'h1000, 16'h0000);
    push_point(16'h0000, 16'h0000, 16'h0000);
    push_point(16'd5000, 16'hffff, 16'h0000);
    push_point(16'h0000, 16'h8000, 16'h0001);
    push_point(16'h0000, 16'h8000, 16'hffff);
    push_point(16'h0000, 16'hffff, 16'd4097);
    push_point(16'h8000, 16'h8000, 16'h0000);
    push_point(16'h7fff, 16'h8000, 16'h1000);
    drain();

    // quarter-turn window about y, near minus-pi window about z
    write_limit(REG_X_LIM, 32'h0000_0000);
    write_limit(REG_Y_LIM, LIM_FULL);
    write_limit(REG_Z_LIM, 32'h0000_0000);
    write_limit(REG_ANG_X_LIM, 32'h0000_0000);
    write_limit(REG_ANG_Y_LIM, {16'd16684, 16'd16084});
    write_limit(REG_ANG_Z_LIM, {16'(-30000), 16'h8000});
    push_point(16'h1000, 16'hffff, 16'h0000);
    push_point(16'h8000, 16'hffff, 16'h0000);
    push_point(16'h8000, 16'hffff, 16'h0001);
    push_point(16'h7fff, 16'h0000, 16'h0000);
    push_point(16'hffff, 16'hffff, 16'h0000);
    drain();

    // reversed bounds never hold
    write_limit(REG_ANG_Y_LIM, {16'hfffb, 16'h0005});
    write_limit(REG_ANG_Z_LIM, 32'h0000_0000);
    push_point(16'h0000, 16'h0000, 16'h0000);
    push_point(16'd100, 16'd100, 16'd100);
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 3) begin
        in_idle_pct = 77;
        out_idle_pct = 27;
      end
      if (ph == 6) begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end
      for (r = 0; r < 6; r++)
        write_limit(crpt_reg_t'(r), (ph == 0) ? LIM_FULL :
                                    (ph == 4) ? LIM_REVERSED : pick_limit());
      if ($urandom_range(1) == 1)
        write_limit($urandom_range(1) ? REG_UNUSED_LO : REG_UNUSED_HI, $urandom);
      n = (ph == 4) ? 10 : 55;
      repeat (n)
        push_point(pick_coord(lim_regs[REG_X_LIM]), pick_coord(lim_regs[REG_Y_LIM]),
                   pick_coord(lim_regs[REG_Z_LIM]));
      drain();
    end

    repeat (CRPT_CORDIC_STEPS + 4) @(posedge clk);
    if (bad_results == 0) begin
      $display("** contact_region_point_test_top: PASSED **");
    end else begin
      $display("** contact_region_point_test_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("** contact_region_point_test_top: FAILED **");
    $finish;
  end

endmodule
